// ----- hdl/dwv_pkg.sv -----
package dwv_pkg;

    localparam int TABLE_SIZE          = 1024;
    localparam int TABLE_BITS          = $clog2(TABLE_SIZE);
    localparam int DRAWBARS            = 9;
    localparam int VOICES              = 16;
    localparam int PHASE_FRACTION_BITS = 16;
    localparam int PH_W                = TABLE_BITS + PHASE_FRACTION_BITS;
    localparam int INC_W               = 26;
    localparam int VOICE_W             = 4;
    localparam int ENV_W               = 16;
    localparam int LVL_W               = 12;
    localparam int LVLX_W              = 13;
    localparam int GAIN_W              = 16;
    localparam int OUT_W               = 24;
    localparam int ACC_W               = 64;
    localparam int ADDR_W              = $clog2(VOICES * DRAWBARS);
    localparam int DB_W                = $clog2(DRAWBARS + 1);

    localparam logic [1:0] CFG_LEVELS_LO = 2'd0;
    localparam logic [1:0] CFG_LEVELS_HI = 2'd1;
    localparam logic [1:0] CFG_HEADROOM  = 2'd2;

    typedef logic signed [15:0] t_rom [TABLE_SIZE];

    typedef struct packed {
        logic [VOICE_W-1:0]              voice;
        logic [DRAWBARS-1:0][INC_W-1:0]  inc;
        logic [ENV_W-1:0]                env;
        logic                            ok;
    } t_item;

    typedef struct packed {
        logic [DRAWBARS-1:0][LVLX_W-1:0] lvl;
        logic [GAIN_W-1:0]               gain;
    } t_cfg;

    localparam longint unsigned DivK [6] = '{6, 20, 42, 72, 110, 156};
    localparam longint unsigned TwoPiQ30 = 64'd6746518852;

    // sin(x), x in [0, pi/2], Q2.30
    function automatic longint sine_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 6; k++) begin
            term = (term * x2) >> 30;
            term = term / DivK[k-1];
            if (k % 2 == 1) sum = sum - longint'(term);
            else            sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > 64'sd1073741824) sum = 64'sd1073741824;
        return sum;
    endfunction

    function automatic t_rom build_rom();
        t_rom            rom;
        longint unsigned turn;
        longint unsigned x;
        longint          mag;
        logic            neg;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            turn = longint'(i) << (32 - TABLE_BITS);
            neg  = 1'b0;
            if (turn >= 64'h8000_0000) begin
                neg  = 1'b1;
                turn = turn - 64'h8000_0000;
            end
            if (turn > 64'h4000_0000) turn = 64'h8000_0000 - turn;
            x   = (turn * TwoPiQ30) >> 32;
            mag = (sine_q30(x) * 32767 + 64'sd536870912) >>> 30;
            if (mag > 32767) mag = 32767;
            rom[i] = neg ? 16'(-mag) : 16'(mag);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

endpackage

// ----- hdl/dwv_front.sv -----
module dwv_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dwv_pkg::VOICE_W-1:0]   i_voice,
    input  logic [dwv_pkg::DRAWBARS-1:0][dwv_pkg::INC_W-1:0] i_inc,
    input  logic [dwv_pkg::ENV_W-1:0]     i_env,
    output logic                          o_item_valid,
    input  logic                          i_item_ready,
    output dwv_pkg::t_item                o_item
);
    import dwv_pkg::*;

    // two-entry queue to the back end
    t_item       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push, pop;
    t_item       item;

    assign o_ready      = (r_cnt != 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];
    assign push         = i_valid && o_ready;
    assign pop          = o_item_valid && i_item_ready;

    always_comb begin
        item.voice = i_voice;
        item.inc   = i_inc;
        item.env   = i_env;
        item.ok    = (int'(i_voice) < VOICES);
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> (r_cnt == 2'd2))
        else $error("full queue lost an entry");

endmodule

// ----- hdl/dwv_back.sv -----
module dwv_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dwv_pkg::t_cfg               i_cfg,
    input  logic                        i_item_valid,
    output logic                        o_item_ready,
    input  dwv_pkg::t_item              i_item,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [dwv_pkg::OUT_W-1:0] o_sample
);
    import dwv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                     r_state;
    t_item                      r_item;
    logic [DB_W-1:0]            r_issue;
    logic                       r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic [DB_W-1:0]            r_s1_d, r_s2_d, r_s3_d, r_s4_d;
    logic [PH_W-1:0]            r_mem [VOICES*DRAWBARS];
    logic                       r_pv  [VOICES*DRAWBARS];
    logic [PH_W-1:0]            r_rd;
    logic                       r_rd_vld;
    logic signed [15:0]         r_sine;
    logic signed [29:0]         r_a;
    logic [31:0]                r_b;
    logic signed [62:0]         r_p;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_out_vld;
    logic signed [OUT_W-1:0]    r_out;

    logic [ADDR_W-1:0]          base, ra, wa;
    logic                       issue, we, last4, out_load;
    logic [PH_W-1:0]            phase;
    logic signed [ACC_W-1:0]    rnd;
    logic signed [28:0]         q;
    logic signed [OUT_W-1:0]    sat;

    assign base  = ADDR_W'(r_item.voice) * ADDR_W'(DRAWBARS);
    assign issue = (r_state == S_RUN) && (r_issue < DB_W'(DRAWBARS));
    assign ra    = base + ADDR_W'(r_issue);
    assign wa    = base + ADDR_W'(r_s1_d);
    assign we    = r_s1_v;
    assign phase = r_rd_vld ? r_rd : '0;
    assign last4 = r_s4_v && (r_s4_d == DB_W'(DRAWBARS - 1));

    assign o_item_ready = (r_state == S_IDLE);
    assign out_load     = (r_state == S_FIN) && (!r_out_vld || i_ready);
    assign o_valid      = r_out_vld;
    assign o_sample     = r_out;

    // round half up at bit 35, then clip
    assign rnd = r_acc + (64'sd1 <<< 34);
    assign q   = 29'(rnd >>> 35);
    always_comb begin
        if (q > 29'sd8388607)       sat = 24'sd8388607;
        else if (q < -29'sd8388608) sat = -24'sd8388608;
        else                        sat = 24'(q);
    end

    // phase memory, read data registered
    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= phase + r_item.inc[r_s1_d];
        r_rd <= r_mem[ra];
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (o_item_ready && i_item_valid) r_item <= i_item;
        r_sine <= SINE_ROM[phase[PH_W-1 -: TABLE_BITS]];
        r_a    <= 30'(r_sine * $signed({1'b0, i_cfg.lvl[r_s2_d]}));
        r_b    <= 32'(r_item.env) * 32'(i_cfg.gain);
        r_p    <= 63'(r_a * $signed({1'b0, r_b}));
        if (out_load) r_out <= sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issue   <= '0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_s4_v    <= 1'b0;
            r_s1_d    <= '0;
            r_s2_d    <= '0;
            r_s3_d    <= '0;
            r_s4_d    <= '0;
            r_rd_vld  <= 1'b0;
            r_acc     <= '0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < VOICES*DRAWBARS; i++) r_pv[i] <= 1'b0;
        end else begin
            r_rd_vld <= r_pv[ra];
            if (we) r_pv[wa] <= 1'b1;
            r_s1_v <= issue;
            r_s1_d <= r_issue;
            r_s2_v <= r_s1_v;
            r_s2_d <= r_s1_d;
            r_s3_v <= r_s2_v;
            r_s3_d <= r_s2_d;
            r_s4_v <= r_s3_v;
            r_s4_d <= r_s3_d;
            if (issue) r_issue <= r_issue + 1'b1;
            if (r_s4_v) r_acc <= r_acc + ACC_W'(r_p);
            if (out_load) r_out_vld <= 1'b1;
            else if (i_ready) r_out_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_acc   <= '0;
                        r_issue <= '0;
                        r_state <= i_item.ok ? S_RUN : S_FIN;
                    end
                end
                S_RUN: begin
                    if (last4) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_mac_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v |-> (r_state == S_RUN)) else $error("accumulate outside run");
    a_fin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> !(r_s1_v || r_s2_v || r_s3_v || r_s4_v))
        else $error("pipeline busy at finish");
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_FIN))
        else $error("result loaded outside finish");
    a_write_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == S_RUN)) else $error("phase write outside run");

endmodule

// ----- hdl/drawbar_wavetable_voice_unit.sv -----
// Drawbar wavetable voice: one 24-bit sample per transfer, nine drawbars summed.
// Steps: the item waits in the front queue until the back end is idle and accepts it,
// then nine phase reads one per cycle, the four-stage multiply/accumulate drain, and
// one output load.
// The back-end sequencer (accept, run, finish) takes one item at a time; the queue holds two.
// Reset (synchronous, active low) clears queue, sequencer, config (headroom 32768)
// and phase valid bits, so all phases read as zero; no clearing pass needed.
module drawbar_wavetable_voice_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [3:0]           i_voice,
    input  logic [25:0]          i_increment_0,
    input  logic [25:0]          i_increment_1,
    input  logic [25:0]          i_increment_2,
    input  logic [25:0]          i_increment_3,
    input  logic [25:0]          i_increment_4,
    input  logic [25:0]          i_increment_5,
    input  logic [25:0]          i_increment_6,
    input  logic [25:0]          i_increment_7,
    input  logic [25:0]          i_increment_8,
    input  logic [15:0]          i_envelope_level,
    // result output
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [23:0]   o_sample_out,
    // config write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data
);
    import dwv_pkg::*;

    logic [59:0]                     r_lv_lo;
    logic [47:0]                     r_lv_hi;
    logic [GAIN_W-1:0]               r_gain;
    logic [DRAWBARS-1:0][LVL_W-1:0]  lvl;
    t_cfg                            cfg;
    logic [DRAWBARS-1:0][INC_W-1:0]  inc;
    t_item                           item;
    logic                            item_valid, item_ready;

    // config is always accepted; unknown index drops the transfer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv_lo <= '0;
            r_lv_hi <= '0;
            r_gain  <= 16'd32768;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEVELS_LO: r_lv_lo <= i_cfg_data[59:0];
                CFG_LEVELS_HI: r_lv_hi <= i_cfg_data[47:0];
                CFG_HEADROOM:  r_gain  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // widen each level so full scale 4095 becomes exactly 4096
    always_comb begin
        for (int d = 0; d < 5; d++) lvl[d] = r_lv_lo[12*d +: 12];
        for (int d = 5; d < DRAWBARS; d++) lvl[d] = r_lv_hi[12*(d-5) +: 12];
        for (int d = 0; d < DRAWBARS; d++)
            cfg.lvl[d] = LVLX_W'(lvl[d]) + LVLX_W'(lvl[d][LVL_W-1]);
        cfg.gain = r_gain;
    end

    assign inc[0] = i_increment_0;
    assign inc[1] = i_increment_1;
    assign inc[2] = i_increment_2;
    assign inc[3] = i_increment_3;
    assign inc[4] = i_increment_4;
    assign inc[5] = i_increment_5;
    assign inc[6] = i_increment_6;
    assign inc[7] = i_increment_7;
    assign inc[8] = i_increment_8;

    // front: accept and tag out-of-range voices, queue two items
    dwv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_voice      (i_voice),
        .i_inc        (inc),
        .i_env        (i_envelope_level),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready),
        .o_item       (item)
    );

    // back: phase sequencer, sine lookup, multiply/accumulate, output register
    dwv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (item_valid),
        .o_item_ready (item_ready),
        .i_item       (item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample     (o_sample_out)
    );

endmodule

// ----- test/dwv_checker.sv -----
`timescale 1ns / 1ps

// Watches the item, config and sample channels. It keeps its own copy of the
// config and the phase store and predicts each sample.
module dwv_checker (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_valid,
    input  logic                                               i_in_ready,
    input  logic [dwv_pkg::VOICE_W-1:0]                        i_voice,
    input  logic [dwv_pkg::DRAWBARS-1:0][dwv_pkg::INC_W-1:0]   i_incs,
    input  logic [dwv_pkg::ENV_W-1:0]                          i_env,
    input  logic                                               i_out_valid,
    input  logic                                               i_out_ready,
    input  logic signed [dwv_pkg::OUT_W-1:0]                   i_sample,
    input  logic                                               i_cfg_valid,
    input  logic                                               i_cfg_ready,
    input  logic [1:0]                                         i_cfg_index,
    input  logic [63:0]                                        i_cfg_data,
    output int                                                 o_errors,
    output int                                                 o_pending
);
    import dwv_pkg::*;

    logic signed [15:0]    sin_lut [TABLE_SIZE];
    logic [PH_W-1:0]       phase_mem [VOICES*DRAWBARS];
    logic [59:0]           levels_lo;
    logic [47:0]           levels_hi;
    logic [GAIN_W-1:0]     headroom;
    logic signed [OUT_W-1:0] sample_q [$];

    // Taylor series for sin(x), x in [0, pi/2], all values Q2.30
    function automatic longint taylor_sin(longint unsigned x);
        longint unsigned sq;
        longint unsigned term;
        longint          acc;
        sq   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= 6; k++) begin
            term = (term * sq) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc -= longint'(term);
            else            acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > 64'sd1073741824) acc = 64'sd1073741824;
        return acc;
    endfunction

    initial begin
        longint unsigned turn;
        longint          mag;
        logic            neg;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            turn = (longint'(i) << 32) / TABLE_SIZE;
            neg  = 1'b0;
            if (turn >= 64'h8000_0000) begin
                neg  = 1'b1;
                turn -= 64'h8000_0000;
            end
            if (turn > 64'h4000_0000) turn = 64'h8000_0000 - turn;
            mag = (taylor_sin((turn * 64'd6746518852) >> 32) * 32767 + 64'sd536870912) >>> 30;
            if (mag > 32767) mag = 32767;
            sin_lut[i] = neg ? 16'(-mag) : 16'(mag);
        end
    end

    // One voice sample; advances the voice's phases as a side effect
    function automatic logic signed [OUT_W-1:0] voice_sample(
        logic [VOICE_W-1:0] v, logic [DRAWBARS-1:0][INC_W-1:0] incs, logic [ENV_W-1:0] env);
        longint          acc;
        longint unsigned lvl;
        longint unsigned biased;
        longint          q;
        int              slot;
        acc = 0;
        if (v >= VOICES) return '0;
        for (int d = 0; d < DRAWBARS; d++) begin
            slot = v * DRAWBARS + d;
            lvl  = (d < 5) ? levels_lo[12*d +: 12] : levels_hi[12*(d-5) +: 12];
            lvl  = lvl + (lvl >> 11);
            acc += longint'(sin_lut[phase_mem[slot][PH_W-1 -: TABLE_BITS]])
                 * longint'(lvl * env * headroom);
            phase_mem[slot] = phase_mem[slot] + incs[d][PH_W-1:0];
        end
        biased = longint'(acc) + 64'h8000_0000_0000_0000 + 64'h4_0000_0000;
        q = longint'(biased >> 35) - (64'sd1 << 28);
        if (q > 8388607)  q = 8388607;
        if (q < -8388608) q = -8388608;
        return q[OUT_W-1:0];
    endfunction

    assign o_pending = sample_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (phase_mem[i]) phase_mem[i] = '0;
            levels_lo = '0;
            levels_hi = '0;
            headroom  = 16'd32768;
            sample_q.delete();
            o_errors  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LEVELS_LO: levels_lo = i_cfg_data[59:0];
                    CFG_LEVELS_HI: levels_hi = i_cfg_data[47:0];
                    CFG_HEADROOM:  headroom  = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (sample_q.size() == 0) begin
                    $display("%0t: sample with none expected: expected none, actual %0d",
                             $time, i_sample);
                    o_errors++;
                end else begin
                    if (i_sample !== sample_q[0]) begin
                        $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                                 $time, sample_q[0], i_sample);
                        o_errors++;
                    end
                    void'(sample_q.pop_front());
                end
            end
            if (i_valid && i_in_ready)
                sample_q.push_back(voice_sample(i_voice, i_incs, i_env));
        end
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import dwv_pkg::*;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [VOICE_W-1:0]             voice = '0;
    logic [DRAWBARS-1:0][INC_W-1:0] incs = '0;
    logic [ENV_W-1:0]               env = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [OUT_W-1:0]        sample;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [1:0]                     cfg_index = CFG_LEVELS_LO;
    logic [63:0]                    cfg_data = '0;
    int                             errors;
    int                             pending;

    // Gaps on both sides only while set; cleared for the tail of the run
    bit                             gaps_on = 1'b1;
    // Request for one long receiver hold-off
    bit                             hold_req = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    drawbar_wavetable_voice_unit u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_voice          (voice),
        .i_increment_0    (incs[0]),
        .i_increment_1    (incs[1]),
        .i_increment_2    (incs[2]),
        .i_increment_3    (incs[3]),
        .i_increment_4    (incs[4]),
        .i_increment_5    (incs[5]),
        .i_increment_6    (incs[6]),
        .i_increment_7    (incs[7]),
        .i_increment_8    (incs[8]),
        .i_envelope_level (env),
        .o_valid          (out_valid),
        .i_ready          (out_ready),
        .o_sample_out     (sample),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    dwv_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .i_in_ready  (in_ready),
        .i_voice     (voice),
        .i_incs      (incs),
        .i_env       (env),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_sample    (sample),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Sample receiver: random short stalls, plus one long hold-off on request
    // so the block backs up and stalls its input.
    initial begin
        int stall;
        stall = 0;
        @(posedge clk iff rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end else if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                stall = $urandom_range(0, 3);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Config write; only called while the block is idle
    task automatic write_reg(logic [1:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Item transfer; valid stays high afterwards so back-to-back items need
    // no extra edge. A random gap drops it first.
    task automatic send_voice(logic [VOICE_W-1:0] v, logic [DRAWBARS-1:0][INC_W-1:0] steps,
                              logic [ENV_W-1:0] e);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        voice    <= v;
        incs     <= steps;
        env      <= e;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid, then wait until every sample has come back
    task automatic drain();
        if (in_valid) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [INC_W-1:0] rand_step();
        case ($urandom_range(0, 3))
            0: return INC_W'($urandom_range(0, 4095));
            1: return INC_W'($urandom_range(0, 32'h3F_FFFF));
            2: return INC_W'($urandom);
            default: return INC_W'($urandom_range(0, 64) << 16);
        endcase
    endfunction

    task automatic random_voices(int n);
        logic [DRAWBARS-1:0][INC_W-1:0] steps;
        logic [ENV_W-1:0]               e;
        for (int k = 0; k < n; k++) begin
            foreach (steps[d]) steps[d] = rand_step();
            e = ($urandom_range(0, 7) == 0) ? ENV_W'($urandom) : ENV_W'($urandom_range(0, 32768));
            send_voice(VOICE_W'($urandom), steps, e);
        end
    endtask

    task automatic random_config();
        write_reg(CFG_LEVELS_LO, {$urandom, $urandom});
        write_reg(CFG_LEVELS_HI, {$urandom, $urandom});
        write_reg(CFG_HEADROOM, 64'($urandom));
    endtask

    initial begin
        logic [DRAWBARS-1:0][INC_W-1:0] steps;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full scale everywhere: data wider than each register checks masking,
        // quarter-table steps hit both peaks so the sum saturates both ways.
        write_reg(CFG_LEVELS_LO, '1);
        write_reg(CFG_LEVELS_HI, '1);
        write_reg(CFG_HEADROOM, '1);
        write_reg(2'd3, 64'h0123_4567_89AB_CDEF);
        foreach (steps[d]) steps[d] = INC_W'(256) << 16;
        for (int k = 0; k < 5; k++) send_voice(4'd0, steps, 16'hFFFF);
        send_voice(4'd15, '0, 16'd32768);
        send_voice(4'd15, '1, 16'd0);
        send_voice(4'd15, '1, 16'hFFFF);
        send_voice(4'd15, '1, 16'd32768);
        // one bit at a time in every step field
        for (int b = 0; b < INC_W; b += 2) begin
            foreach (steps[d]) steps[d] = INC_W'(1) << ((b + d) % INC_W);
            send_voice(VOICE_W'(b), steps, 16'(1 << (b % ENV_W)));
        end
        drain();

        // Levels and gain zero: silence whatever the phase
        write_reg(CFG_LEVELS_LO, '0);
        write_reg(CFG_LEVELS_HI, '0);
        write_reg(CFG_HEADROOM, '0);
        random_voices(40);
        drain();

        // Unity levels, default headroom
        write_reg(CFG_LEVELS_LO, {5{12'hFFF}});
        write_reg(CFG_LEVELS_HI, {4{12'hFFF}});
        write_reg(CFG_HEADROOM, 64'd32768);
        random_voices(200);
        hold_req = 1'b1;
        random_voices(60);
        drain();

        for (int p = 0; p < 4; p++) begin
            random_config();
            random_voices(170);
            drain();
        end

        // Tail with no gaps on either side
        gaps_on = 1'b0;
        random_config();
        random_voices(150);
        drain();

        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
